[hw/rtl/bpc_pkg.sv]
// bpc_pkg: shared types, constants and the polynomial op program for the
// barometric pressure compensation block. No dependencies.

package bpc_pkg;

	localparam int DEF_FRAC_BITS = 24;

	localparam int RAW_W       = 24;
	localparam int SCALED_W    = 32;
	localparam int TERM_W      = 64;
	localparam int COEF_WIDE_W = 20;
	localparam int COEF_W      = 16;
	localparam int SF_W        = 23;
	localparam int OUT_W       = 32;

	localparam int CFG_IDX_W  = 3;
	localparam int CFG_DATA_W = 23;

	localparam logic [SF_W-1:0]   SCALE_RESET = 23'd253952;
	localparam logic [TERM_W-1:0] TERM_LIM    = 64'h1FFF_FFFF_FFFF_FFFF;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_COEF_OFFSET,
		REG_COEF_LINEAR,
		REG_COEF_TEMP,
		REG_COEF_CROSS,
		REG_COEF_SQUARE,
		REG_COEF_CROSS_SQUARE,
		REG_COEF_CUBE,
		REG_SCALE_FACTOR
	} cfg_reg_t;

	typedef struct packed {
		logic                    temp_ready;
		logic signed [RAW_W-1:0] temp_raw;
		logic                    pres_ready;
		logic signed [RAW_W-1:0] pres_raw;
	} sample_t;

	typedef struct packed {
		logic signed [OUT_W-1:0] pressure;
		logic                    saturated;
	} result_t;

	// handshake-free status of a multi-cycle unit
	typedef struct packed {
		logic done;
		logic clipped;
	} unit_stat_t;

	// operands of one multiply-accumulate: addend + (a * b) / 2^frac, or addend + a when add_only
	typedef struct packed {
		logic signed [TERM_W-1:0]   a;
		logic signed [SCALED_W-1:0] b;
		logic signed [TERM_W-1:0]   addend;
		logic                       add_only;
	} mac_req_t;

	typedef enum logic [2:0] {
		OPA_C30,
		OPA_C21,
		OPA_C01,
		OPA_T0,
		OPA_T1,
		OPA_T2
	} opa_sel_t;

	typedef enum logic {
		OPB_PRES,
		OPB_TEMP
	} opb_sel_t;

	typedef enum logic [2:0] {
		ADD_ZERO,
		ADD_C20,
		ADD_C10,
		ADD_C00,
		ADD_C11,
		ADD_T0
	} add_sel_t;

	typedef enum logic [1:0] {
		DST_T0,
		DST_T1,
		DST_T2
	} dst_sel_t;

	typedef struct packed {
		opa_sel_t a_sel;
		opb_sel_t b_sel;
		add_sel_t add_sel;
		logic     add_only;
		dst_sel_t dst;
	} mac_op_t;

	localparam int OP_IDX_W = 4;
	localparam int NUM_OPS  = 9;
	localparam logic [OP_IDX_W-1:0] LAST_OP = OP_IDX_W'(NUM_OPS - 1);

	// horner form for the pressure part, then the temperature terms, then sums
	function automatic mac_op_t bpc_op(input logic [OP_IDX_W-1:0] idx);
		mac_op_t op;
		op = '{a_sel: OPA_T0, b_sel: OPB_PRES, add_sel: ADD_ZERO, add_only: 1'b0,
			dst: DST_T0};
		case (idx)
			4'd0: op = '{OPA_C30, OPB_PRES, ADD_C20, 1'b0, DST_T0};
			4'd1: op = '{OPA_T0,  OPB_PRES, ADD_C10, 1'b0, DST_T0};
			4'd2: op = '{OPA_T0,  OPB_PRES, ADD_C00, 1'b0, DST_T0};
			4'd3: op = '{OPA_C21, OPB_PRES, ADD_C11, 1'b0, DST_T1};
			4'd4: op = '{OPA_T1,  OPB_PRES, ADD_ZERO, 1'b0, DST_T1};
			4'd5: op = '{OPA_T1,  OPB_TEMP, ADD_ZERO, 1'b0, DST_T1};
			4'd6: op = '{OPA_C01, OPB_TEMP, ADD_ZERO, 1'b0, DST_T2};
			4'd7: op = '{OPA_T2,  OPB_PRES, ADD_T0,  1'b1, DST_T0};
			4'd8: op = '{OPA_T1,  OPB_PRES, ADD_T0,  1'b1, DST_T0};
			default: op = '{OPA_T0, OPB_PRES, ADD_ZERO, 1'b0, DST_T0};
		endcase
		return op;
	endfunction

endpackage

[hw/rtl/baro_pressure_compensation.sv]
// baro_pressure_compensation: a pressure request is scaled by the divider (one quotient
// bit a cycle), run through nine polynomial steps on the shared multiplier (two passes per
// product) and rounded; a temperature in the request is scaled first.
// one request at a time, the next taken the cycle after the result is loaded; a
// temperature-only request ends with no result; a held result stalls the next emit.
// reset sets coefficients to 0, scale factor to 253952, kept temperature to 0, no clearing.

module baro_pressure_compensation import bpc_pkg::*; #(
	parameter int FRAC_BITS = DEF_FRAC_BITS
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  sample_valid,
	output logic                  sample_stall,
	input  sample_t               sample,
	output logic                  result_valid,
	input  logic                  result_stall,
	output result_t               result,
	input  logic                  cfg_we,
	input  logic [CFG_IDX_W-1:0]  cfg_index,
	input  logic [CFG_DATA_W-1:0] cfg_data
);

	// output rounding: half of one output lsb, clip limits of the 32-bit result
	localparam logic [TERM_W-1:0] RND_HALF    = TERM_W'(1) << (FRAC_BITS - 7);
	localparam logic [TERM_W-1:0] OUT_POS_MAX = (TERM_W'(1) << (OUT_W - 1)) - TERM_W'(1);
	localparam logic [TERM_W-1:0] OUT_NEG_MAX = TERM_W'(1) << (OUT_W - 1);

	typedef enum logic [2:0] {
		S_IDLE,
		S_TDIV,
		S_PDIV,
		S_OP,
		S_RND,
		S_EMIT
	} state_t;

	// calibration registers
	logic signed [COEF_WIDE_W-1:0] coef_offset_q;
	logic signed [COEF_WIDE_W-1:0] coef_linear_q;
	logic signed [COEF_W-1:0]      coef_temp_q;
	logic signed [COEF_W-1:0]      coef_cross_q;
	logic signed [COEF_W-1:0]      coef_square_q;
	logic signed [COEF_W-1:0]      coef_cross_square_q;
	logic signed [COEF_W-1:0]      coef_cube_q;
	logic [SF_W-1:0]               scale_factor_q;

	// sequencer state and working registers
	state_t                     state_q;
	logic                       pres_ready_q;
	logic signed [RAW_W-1:0]    pres_raw_q;
	logic signed [RAW_W-1:0]    div_raw_q;
	logic                       div_go_q;
	logic                       mac_go_q;
	logic [OP_IDX_W-1:0]        op_idx_q;
	logic signed [SCALED_W-1:0] temp_q;
	logic signed [SCALED_W-1:0] p_q;
	logic signed [TERM_W-1:0]   t0_q;
	logic signed [TERM_W-1:0]   t1_q;
	logic signed [TERM_W-1:0]   t2_q;
	logic                       sat_q;
	logic [TERM_W-1:0]          rnd_q;
	logic                       rneg_q;
	logic                       result_valid_q;
	result_t                    result_q;

	// unit interfaces
	unit_stat_t                 div_stat;
	logic signed [SCALED_W-1:0] div_value;
	unit_stat_t                 mac_stat;
	logic signed [TERM_W-1:0]   mac_result;
	mac_req_t                   mac_req;
	mac_op_t                    op;

	// final rounding and clipping
	logic [TERM_W-1:0]   rq;
	logic                fin_pos_ovf;
	logic                fin_neg_ovf;
	logic [OUT_W-1:0]    fin_mag;
	logic signed [OUT_W-1:0] fin_val;

	// coefficient in the internal term format: c * 2^frac
	function automatic logic signed [TERM_W-1:0] coefq(
		input logic signed [COEF_WIDE_W-1:0] c
	);
		return {{(TERM_W-COEF_WIDE_W){c[COEF_WIDE_W-1]}}, c} << FRAC_BITS;
	endfunction

	// config port: the user must write it only while no request is in flight; not enforced here
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			coef_offset_q       <= '0;
			coef_linear_q       <= '0;
			coef_temp_q         <= '0;
			coef_cross_q        <= '0;
			coef_square_q       <= '0;
			coef_cross_square_q <= '0;
			coef_cube_q         <= '0;
			scale_factor_q      <= SCALE_RESET;
		end else if (cfg_we) begin
			case (cfg_reg_t'(cfg_index))
				REG_COEF_OFFSET:       coef_offset_q       <= cfg_data[COEF_WIDE_W-1:0];
				REG_COEF_LINEAR:       coef_linear_q       <= cfg_data[COEF_WIDE_W-1:0];
				REG_COEF_TEMP:         coef_temp_q         <= cfg_data[COEF_W-1:0];
				REG_COEF_CROSS:        coef_cross_q        <= cfg_data[COEF_W-1:0];
				REG_COEF_SQUARE:       coef_square_q       <= cfg_data[COEF_W-1:0];
				REG_COEF_CROSS_SQUARE: coef_cross_square_q <= cfg_data[COEF_W-1:0];
				REG_COEF_CUBE:         coef_cube_q         <= cfg_data[COEF_W-1:0];
				REG_SCALE_FACTOR:      scale_factor_q      <= cfg_data[SF_W-1:0];
				default: ;
			endcase
		end
	end

	// one divider scales both the temperature and the pressure reading
	bpc_scale_div #(
		.FRAC_BITS(FRAC_BITS)
	) u_div (
		.clk     (clk),
		.arst_n  (arst_n),
		.go      (div_go_q),
		.raw     (div_raw_q),
		.divisor (scale_factor_q),
		.stat    (div_stat),
		.value   (div_value)
	);

	// operand selection for the current polynomial step
	always_comb begin
		op = bpc_op(op_idx_q);
		case (op.a_sel)
			OPA_C30: mac_req.a = coefq(COEF_WIDE_W'(coef_cube_q));
			OPA_C21: mac_req.a = coefq(COEF_WIDE_W'(coef_cross_square_q));
			OPA_C01: mac_req.a = coefq(COEF_WIDE_W'(coef_temp_q));
			OPA_T0:  mac_req.a = t0_q;
			OPA_T1:  mac_req.a = t1_q;
			OPA_T2:  mac_req.a = t2_q;
			default: mac_req.a = t0_q;
		endcase
		case (op.b_sel)
			OPB_PRES: mac_req.b = p_q;
			OPB_TEMP: mac_req.b = temp_q;
			default:  mac_req.b = p_q;
		endcase
		case (op.add_sel)
			ADD_ZERO: mac_req.addend = '0;
			ADD_C20:  mac_req.addend = coefq(COEF_WIDE_W'(coef_square_q));
			ADD_C10:  mac_req.addend = coefq(coef_linear_q);
			ADD_C00:  mac_req.addend = coefq(coef_offset_q);
			ADD_C11:  mac_req.addend = coefq(COEF_WIDE_W'(coef_cross_q));
			ADD_T0:   mac_req.addend = t0_q;
			default:  mac_req.addend = '0;
		endcase
		mac_req.add_only = op.add_only;
	end

	// shared multiply-accumulate unit runs all nine polynomial steps
	bpc_mulacc #(
		.FRAC_BITS(FRAC_BITS)
	) u_mac (
		.clk    (clk),
		.arst_n (arst_n),
		.go     (mac_go_q),
		.req    (mac_req),
		.stat   (mac_stat),
		.result (mac_result)
	);

	// output scaling to 1/64 Pa with clipping
	always_comb begin
		rq          = rnd_q >> (FRAC_BITS - 6);
		fin_pos_ovf = !rneg_q && (rq > OUT_POS_MAX);
		fin_neg_ovf = rneg_q && (rq > OUT_NEG_MAX);
		fin_mag     = fin_pos_ovf ? OUT_POS_MAX[OUT_W-1:0] :
			fin_neg_ovf ? OUT_NEG_MAX[OUT_W-1:0] : rq[OUT_W-1:0];
		fin_val     = rneg_q ? signed'(OUT_W'(0) - fin_mag) : signed'(fin_mag);
	end

	// sequencer: temperature scaling, pressure scaling, polynomial, rounding
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q        <= S_IDLE;
			pres_ready_q   <= 1'b0;
			pres_raw_q     <= '0;
			div_raw_q      <= '0;
			div_go_q       <= 1'b0;
			mac_go_q       <= 1'b0;
			op_idx_q       <= '0;
			temp_q         <= '0;
			p_q            <= '0;
			t0_q           <= '0;
			t1_q           <= '0;
			t2_q           <= '0;
			sat_q          <= 1'b0;
			rnd_q          <= '0;
			rneg_q         <= 1'b0;
			result_valid_q <= 1'b0;
			result_q       <= '0;
		end else begin
			div_go_q <= 1'b0;
			mac_go_q <= 1'b0;
			if (result_valid_q && !result_stall) begin
				result_valid_q <= 1'b0;
			end
			case (state_q)
				S_IDLE: begin
					if (sample_valid) begin
						pres_ready_q <= sample.pres_ready;
						pres_raw_q   <= sample.pres_raw;
						if (sample.temp_ready) begin
							// temperature goes first so a combined request uses it
							div_raw_q <= sample.temp_raw;
							div_go_q  <= 1'b1;
							state_q   <= S_TDIV;
						end else if (sample.pres_ready) begin
							div_raw_q <= sample.pres_raw;
							div_go_q  <= 1'b1;
							state_q   <= S_PDIV;
						end
					end
				end
				S_TDIV: begin
					if (div_stat.done) begin
						// kept temperature clips silently
						temp_q <= div_value;
						if (pres_ready_q) begin
							div_raw_q <= pres_raw_q;
							div_go_q  <= 1'b1;
							state_q   <= S_PDIV;
						end else begin
							state_q <= S_IDLE;
						end
					end
				end
				S_PDIV: begin
					if (div_stat.done) begin
						p_q      <= div_value;
						sat_q    <= div_stat.clipped;
						op_idx_q <= '0;
						mac_go_q <= 1'b1;
						state_q  <= S_OP;
					end
				end
				S_OP: begin
					if (mac_stat.done) begin
						case (op.dst)
							DST_T0:  t0_q <= mac_result;
							DST_T1:  t1_q <= mac_result;
							DST_T2:  t2_q <= mac_result;
							default: t0_q <= mac_result;
						endcase
						sat_q <= sat_q || mac_stat.clipped;
						if (op_idx_q == LAST_OP) begin
							state_q <= S_RND;
						end else begin
							op_idx_q <= op_idx_q + 1'b1;
							mac_go_q <= 1'b1;
						end
					end
				end
				S_RND: begin
					// magnitude plus half lsb, sign kept apart
					rnd_q   <= t0_q[TERM_W-1] ? (RND_HALF - TERM_W'(t0_q)) :
						(TERM_W'(t0_q) + RND_HALF);
					rneg_q  <= t0_q[TERM_W-1];
					state_q <= S_EMIT;
				end
				S_EMIT: begin
					// wait here only while the previous result is still held
					if (!result_valid_q) begin
						result_q.pressure  <= fin_val;
						result_q.saturated <= sat_q || fin_pos_ovf || fin_neg_ovf;
						result_valid_q     <= 1'b1;
						state_q            <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	assign sample_stall = (state_q != S_IDLE);
	assign result_valid = result_valid_q;
	assign result       = result_q;

	// multiply-accumulate results only arrive while the polynomial runs
	a_mac_done_in_op: assert property (@(posedge clk) disable iff (!arst_n)
		mac_stat.done |-> state_q == S_OP)
		else $error("mac result outside polynomial phase");

	// scaling results only arrive while a scaling is awaited
	a_div_done_in_div: assert property (@(posedge clk) disable iff (!arst_n)
		div_stat.done |-> (state_q == S_TDIV || state_q == S_PDIV))
		else $error("divider result outside scaling phase");

	// a result appears only out of the emit step
	a_result_from_emit: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(result_valid_q) |-> $past(state_q) == S_EMIT)
		else $error("result raised outside emit step");

	// a new request never lands while a unit start is pending
	a_accept_units_quiet: assert property (@(posedge clk) disable iff (!arst_n)
		(sample_valid && !sample_stall) |-> (!div_go_q && !mac_go_q))
		else $error("request accepted with a unit start pending");

	// the program counter stays within the op program
	a_op_idx_range: assert property (@(posedge clk) disable iff (!arst_n)
		op_idx_q <= LAST_OP)
		else $error("op index past end of program");

endmodule

[hw/rtl/bpc_scale_div.sv]
// bpc_scale_div: bit-serial restoring divider that scales a raw reading
// into signed fixed point with rounding and clipping. Depends on bpc_pkg.

module bpc_scale_div import bpc_pkg::*; #(
	parameter int FRAC_BITS = DEF_FRAC_BITS
) (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       go,
	input  logic signed [RAW_W-1:0]    raw,
	input  logic [SF_W-1:0]            divisor,
	output unit_stat_t                 stat,
	output logic signed [SCALED_W-1:0] value
);

	localparam int DW    = RAW_W + FRAC_BITS;
	localparam int QW    = SCALED_W + 1;
	localparam int HW    = DW - QW;
	localparam int CNT_W = $clog2(QW);

	localparam logic [QW-1:0] POS_MAX = (QW'(1) << (SCALED_W - 1)) - QW'(1);
	localparam logic [QW-1:0] NEG_MAX = QW'(1) << (SCALED_W - 1);

	typedef enum logic [1:0] {D_IDLE, D_RUN, D_FIN} dstate_t;

	dstate_t                    state_q;
	logic [SF_W-1:0]            sf_q;
	logic                       neg_q;
	logic [SF_W-1:0]            rem_q;
	logic [QW-1:0]              dvd_q;
	logic [CNT_W-1:0]           cnt_q;
	logic signed [SCALED_W-1:0] value_q;
	logic                       done_q;
	logic                       clip_q;

	logic [SF_W-1:0]  sf_eff;
	logic [RAW_W-1:0] mag;
	logic [DW-1:0]    dvd_full;
	logic [HW-1:0]    dvd_hi;
	logic             ovf;
	logic [SF_W:0]    r2;
	logic [SF_W:0]    r2_sub;
	logic             ge;
	logic             pos_ovf;
	logic             neg_ovf;
	logic [SCALED_W-1:0] q_lim;

	always_comb begin
		sf_eff   = (divisor == '0) ? SF_W'(1) : divisor;
		mag      = raw[RAW_W-1] ? RAW_W'(-raw) : RAW_W'(raw);
		dvd_full = {mag, {FRAC_BITS{1'b0}}} + DW'(sf_eff >> 1);
		dvd_hi   = dvd_full[DW-1:QW];
		// quotient of 2^33 or more: clip without iterating
		ovf      = SF_W'(dvd_hi) >= sf_eff;
		r2       = {rem_q, dvd_q[QW-1]};
		r2_sub   = r2 - {1'b0, sf_q};
		ge       = r2 >= {1'b0, sf_q};
		pos_ovf  = !neg_q && (dvd_q > POS_MAX);
		neg_ovf  = neg_q && (dvd_q > NEG_MAX);
		q_lim    = pos_ovf ? POS_MAX[SCALED_W-1:0] :
			neg_ovf ? NEG_MAX[SCALED_W-1:0] : dvd_q[SCALED_W-1:0];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= D_IDLE;
			sf_q    <= '0;
			neg_q   <= 1'b0;
			rem_q   <= '0;
			dvd_q   <= '0;
			cnt_q   <= '0;
			value_q <= '0;
			done_q  <= 1'b0;
			clip_q  <= 1'b0;
		end else begin
			done_q <= 1'b0;
			case (state_q)
				D_IDLE: begin
					if (go) begin
						sf_q  <= sf_eff;
						neg_q <= raw[RAW_W-1];
						cnt_q <= CNT_W'(QW - 1);
						if (ovf) begin
							dvd_q   <= '1;
							state_q <= D_FIN;
						end else begin
							rem_q   <= SF_W'(dvd_hi);
							dvd_q   <= dvd_full[QW-1:0];
							state_q <= D_RUN;
						end
					end
				end
				D_RUN: begin
					rem_q <= ge ? r2_sub[SF_W-1:0] : r2[SF_W-1:0];
					dvd_q <= {dvd_q[QW-2:0], ge};
					cnt_q <= cnt_q - 1'b1;
					if (cnt_q == '0) begin
						state_q <= D_FIN;
					end
				end
				D_FIN: begin
					value_q <= neg_q ? signed'(SCALED_W'(0) - q_lim) : signed'(q_lim);
					clip_q  <= pos_ovf || neg_ovf;
					done_q  <= 1'b1;
					state_q <= D_IDLE;
				end
				default: begin
					state_q <= D_IDLE;
				end
			endcase
		end
	end

	assign stat.done    = done_q;
	assign stat.clipped = clip_q;
	assign value        = value_q;

endmodule

[hw/rtl/bpc_mulacc.sv]
// bpc_mulacc: shared fixed-point multiply-accumulate unit; one 32x32
// multiplier used twice per product, then term clipping. Depends on bpc_pkg.

module bpc_mulacc import bpc_pkg::*; #(
	parameter int FRAC_BITS = DEF_FRAC_BITS
) (
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     go,
	input  mac_req_t                 req,
	output unit_stat_t               stat,
	output logic signed [TERM_W-1:0] result
);

	localparam int SH = SCALED_W - FRAC_BITS;
	localparam logic [TERM_W-1:0] HI_LIM = TERM_LIM >> SH;

	typedef enum logic [2:0] {M_IDLE, M_HI, M_LO, M_COMB, M_ACC} mstate_t;

	mstate_t                  state_q;
	logic [TERM_W-1:0]        ua_q;
	logic [SCALED_W-1:0]      ub_q;
	logic signed [TERM_W-1:0] addend_q;
	logic [TERM_W-1:0]        hi_q;
	logic [TERM_W-1:0]        lo_q;
	logic [TERM_W-1:0]        rmag_q;
	logic                     rneg_q;
	logic                     mclip_q;
	logic signed [TERM_W-1:0] result_q;
	logic                     done_q;
	logic                     clip_q;

	logic [TERM_W-1:0]        a_mag;
	logic [SCALED_W-1:0]      b_mag;
	logic [SCALED_W-1:0]      mul_a;
	logic [TERM_W-1:0]        prod;
	logic [TERM_W-1:0]        comb_sum;
	logic signed [TERM_W-1:0] acc_sum;
	logic                     acc_hi;
	logic                     acc_lo;

	always_comb begin
		a_mag    = req.a[TERM_W-1] ? TERM_W'(-req.a) : TERM_W'(req.a);
		b_mag    = req.b[SCALED_W-1] ? SCALED_W'(-req.b) : SCALED_W'(req.b);
		mul_a    = (state_q == M_HI) ? ua_q[TERM_W-1:SCALED_W] : ua_q[SCALED_W-1:0];
		prod     = TERM_W'(mul_a) * TERM_W'(ub_q);
		comb_sum = (hi_q << SH) + (lo_q >> FRAC_BITS);
		acc_sum  = rneg_q ? (addend_q - signed'(rmag_q)) : (addend_q + signed'(rmag_q));
		acc_hi   = acc_sum > signed'(TERM_LIM);
		acc_lo   = acc_sum < -signed'(TERM_LIM);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= M_IDLE;
			ua_q     <= '0;
			ub_q     <= '0;
			addend_q <= '0;
			hi_q     <= '0;
			lo_q     <= '0;
			rmag_q   <= '0;
			rneg_q   <= 1'b0;
			mclip_q  <= 1'b0;
			result_q <= '0;
			done_q   <= 1'b0;
			clip_q   <= 1'b0;
		end else begin
			done_q <= 1'b0;
			case (state_q)
				M_IDLE: begin
					if (go) begin
						addend_q <= req.addend;
						mclip_q  <= 1'b0;
						if (req.add_only) begin
							rmag_q  <= a_mag;
							rneg_q  <= req.a[TERM_W-1];
							state_q <= M_ACC;
						end else begin
							ua_q    <= a_mag;
							ub_q    <= b_mag;
							rneg_q  <= req.a[TERM_W-1] ^ req.b[SCALED_W-1];
							state_q <= M_HI;
						end
					end
				end
				M_HI: begin
					hi_q    <= prod;
					state_q <= M_LO;
				end
				M_LO: begin
					lo_q    <= prod;
					state_q <= M_COMB;
				end
				M_COMB: begin
					// product magnitude truncated toward zero, clipped
					if (hi_q > HI_LIM) begin
						rmag_q  <= TERM_LIM;
						mclip_q <= 1'b1;
					end else if (comb_sum > TERM_LIM) begin
						rmag_q  <= TERM_LIM;
						mclip_q <= 1'b1;
					end else begin
						rmag_q <= comb_sum;
					end
					state_q <= M_ACC;
				end
				M_ACC: begin
					if (acc_hi) begin
						result_q <= signed'(TERM_LIM);
					end else if (acc_lo) begin
						result_q <= -signed'(TERM_LIM);
					end else begin
						result_q <= acc_sum;
					end
					clip_q  <= mclip_q || acc_hi || acc_lo;
					done_q  <= 1'b1;
					state_q <= M_IDLE;
				end
				default: begin
					state_q <= M_IDLE;
				end
			endcase
		end
	end

	assign stat.done    = done_q;
	assign stat.clipped = clip_q;
	assign result       = result_q;

endmodule
